/* rtl/scalar_kalman_voltage_filter_unit_macros.svh */
// Assertion macros used by the checker file.
`ifndef SCALAR_KALMAN_VOLTAGE_FILTER_UNIT_MACROS_SVH
`define SCALAR_KALMAN_VOLTAGE_FILTER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SKF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SKF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/skf_pkg.sv */
package skf_pkg;

    localparam int MV_W      = 14;
    localparam int NOISE_W   = 26;
    localparam int EST_W     = 30;
    localparam int COV_W     = 28;
    localparam int PPRED_W   = 29;
    localparam int DENOM_W   = 30;
    localparam int INNOV_W   = 31;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    localparam logic [MV_W-1:0] INIT_MV_RESET = 14'd1650;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ESTIMATE  = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } skf_div_stat_t;

endpackage

/* rtl/skf_div.sv */
module skf_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [skf_pkg::PPRED_W-1:0]  numer,
    input  logic [skf_pkg::DENOM_W-1:0]  denom,
    output skf_pkg::skf_div_stat_t       stat,
    output logic [FRAC_BITS:0]           quot
);
    import skf_pkg::*;

    localparam int STEPS = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [CNT_W-1:0]   cnt_reg;
    logic               done_reg;
    logic [DENOM_W:0]   rem_reg;
    logic [FRAC_BITS:0] quot_reg;

    logic [DENOM_W+1:0] diff_c;
    logic               ge_c;
    logic [DENOM_W:0]   kept_c;
    logic [DENOM_W:0]   rem_next;

    // One restoring step: compare, subtract, shift.
    always_comb
    begin
        diff_c   = {1'b0, rem_reg} - {2'b00, denom};
        ge_c     = !diff_c[DENOM_W+1];
        kept_c   = ge_c ? diff_c[DENOM_W:0] : rem_reg;
        rem_next = {kept_c[DENOM_W-1:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            // Pulse done as the last quotient bit is retired.
            done_reg <= !start && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                cnt_reg <= CNT_W'(STEPS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {2'b00, numer};
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[FRAC_BITS-1:0], ge_c};
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

/* rtl/scalar_kalman_voltage_filter_unit.sv */
// A filtering item runs through ST_DIV, ST_MULK, ST_UPD, ST_COV and ST_FIN before its result is
// registered at the output; a seeding item goes from ST_IDLE straight to ST_FIN.
// Items are taken one at a time (ready only in ST_IDLE), and ST_FIN waits while the output is stalled;
// a filtering item is held in ST_DIV by the serial gain divider that retires one quotient bit a cycle.
// Reset (rst_n, asynchronous, active low): Q = 1.0, R = 50.0, estimate = 1650 mV,
// covariance = 100.0, filter seeded, no result pending.
module scalar_kalman_voltage_filter_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [skf_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // [13:0] sample_mv
    input  logic                           s_axis_tuser,   // [0] restart
    // Result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [skf_pkg::M_TDATA_W-1:0]  m_axis_tdata,   // [13:0] filtered_mv, [27:14] deviation_mv
    output logic                           m_axis_tuser,   // [0] seeded_now
    // Configuration write port
    input  logic                           cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [skf_pkg::NOISE_W-1:0]    cfg_data
);
    import skf_pkg::*;

    localparam int GAIN_W = FRAC_BITS + 1;
    localparam int PROD_W = GAIN_W + 1 + INNOV_W;
    localparam int SHR_W  = PROD_W - FRAC_BITS;

    localparam logic [GAIN_W-1:0]  FX_ONE   = GAIN_W'(1) << FRAC_BITS;
    localparam logic [COV_W-1:0]   COV_SEED = COV_W'(100) << FRAC_BITS;
    localparam logic [NOISE_W-1:0] Q_SEED   = NOISE_W'(1) << FRAC_BITS;
    localparam logic [NOISE_W-1:0] R_SEED   = NOISE_W'(50) << FRAC_BITS;
    localparam logic [EST_W-1:0]   EST_INIT = EST_W'(INIT_MV_RESET) << FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MULK,
        ST_UPD,
        ST_COV,
        ST_FIN
    } state_t;

    state_t state_reg;

    // Filter state and noise settings
    logic [NOISE_W-1:0] q_reg;
    logic [NOISE_W-1:0] r_reg;
    logic [EST_W-1:0]   est_reg;
    logic [COV_W-1:0]   cov_reg;
    logic               seeded_reg;

    // Per-item working registers
    logic [MV_W-1:0]           meas_reg;
    logic signed [INNOV_W-1:0] innov_reg;
    logic [PPRED_W-1:0]        ppred_reg;
    logic [DENOM_W-1:0]        denom_reg;
    logic                      denom_zero_reg;
    logic [GAIN_W-1:0]         gain_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    // Finished result, then the output register
    logic [MV_W-1:0] res_filt_reg;
    logic [MV_W-1:0] res_dev_reg;
    logic            res_seed_reg;
    logic            out_valid_reg;
    logic [MV_W-1:0] out_filt_reg;
    logic [MV_W-1:0] out_dev_reg;
    logic            out_seed_reg;

    logic [MV_W-1:0]           meas_c;
    logic [EST_W-1:0]          meas_fx_c;
    logic                      accept_c;
    logic                      seed_path_c;
    logic [PPRED_W-1:0]        ppred_c;
    logic [DENOM_W-1:0]        denom_c;
    logic signed [INNOV_W-1:0] innov_c;
    logic signed [GAIN_W:0]    mul_a_c;
    logic signed [INNOV_W-1:0] mul_b_c;
    logic signed [PROD_W-1:0]  mul_p_c;
    logic signed [SHR_W-1:0]   delta_c;
    logic signed [SHR_W:0]     est_sum_c;
    logic [EST_W-1:0]          est_new_c;
    logic [SHR_W-1:0]          cov_shr_c;
    logic [COV_W-1:0]          cov_new_c;
    logic [MV_W-1:0]           filt_c;
    logic [MV_W-1:0]           dev_c;
    logic                      div_start_c;
    skf_div_stat_t             div_stat;
    logic [FRAC_BITS:0]        div_quot;

    assign meas_c      = s_axis_tdata[MV_W-1:0];
    assign meas_fx_c   = EST_W'(meas_c) << FRAC_BITS;
    assign accept_c    = s_axis_tvalid && s_axis_tready;
    assign seed_path_c = s_axis_tuser || !seeded_reg;
    assign div_start_c = accept_c && !seed_path_c;

    // Predict: P' = P + Q, and the gain denominator P' + R.
    assign ppred_c = PPRED_W'(cov_reg) + PPRED_W'(q_reg);
    assign denom_c = DENOM_W'(ppred_c) + DENOM_W'(r_reg);
    assign innov_c = $signed({1'b0, meas_fx_c}) - $signed({1'b0, est_reg});

    // Shared multiplier: K * innovation first, then (1 - K) * P'.
    always_comb
    begin
        if (state_reg == ST_MULK)
        begin
            mul_a_c = $signed({1'b0, gain_reg});
            mul_b_c = innov_reg;
        end
        else
        begin
            mul_a_c = $signed({1'b0, FX_ONE - gain_reg});
            mul_b_c = $signed({2'b00, ppred_reg});
        end
    end

    assign mul_p_c = mul_a_c * mul_b_c;

    // Arithmetic shift floors toward minus infinity; clamp a negative sum to zero.
    assign delta_c   = $signed(prod_reg[PROD_W-1:FRAC_BITS]);
    assign est_sum_c = $signed({delta_c[SHR_W-1], delta_c})
                     + $signed({{(SHR_W+1-EST_W){1'b0}}, est_reg});
    assign est_new_c = est_sum_c[SHR_W] ? '0 : est_sum_c[EST_W-1:0];

    // Covariance update saturates at its full width.
    assign cov_shr_c = prod_reg[PROD_W-1:FRAC_BITS];
    assign cov_new_c = (|cov_shr_c[SHR_W-1:COV_W]) ? '1 : cov_shr_c[COV_W-1:0];

    assign filt_c = est_reg[FRAC_BITS +: MV_W];
    assign dev_c  = (meas_reg >= filt_c) ? (meas_reg - filt_c) : (filt_c - meas_reg);

    skf_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_skf_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_c),
        .numer (ppred_c),
        .denom (denom_reg),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            q_reg          <= Q_SEED;
            r_reg          <= R_SEED;
            est_reg        <= EST_INIT;
            cov_reg        <= COV_SEED;
            seeded_reg     <= 1'b1;
            meas_reg       <= '0;
            innov_reg      <= '0;
            ppred_reg      <= '0;
            denom_reg      <= '0;
            denom_zero_reg <= 1'b0;
            gain_reg       <= '0;
            prod_reg       <= '0;
            res_filt_reg   <= '0;
            res_dev_reg    <= '0;
            res_seed_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_filt_reg   <= '0;
            out_dev_reg    <= '0;
            out_seed_reg   <= 1'b0;
        end
        else
        begin
            // Drop the result once the downstream transaction completes, unless
            // the next one is loaded in the same cycle.
            if (out_valid_reg && m_axis_tready && (state_reg != ST_FIN))
            begin
                out_valid_reg <= 1'b0;
            end

            // Register writes; the user must issue them only while idle, as the block itself does not enforce it.
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PROCESS_NOISE:
                    begin
                        q_reg <= cfg_data;
                    end
                    CFG_MEASUREMENT_NOISE:
                    begin
                        r_reg <= cfg_data;
                    end
                    CFG_INITIAL_ESTIMATE:
                    begin
                        est_reg    <= EST_W'(cfg_data[MV_W-1:0]) << FRAC_BITS;
                        cov_reg    <= COV_SEED;
                        seeded_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept_c)
                    begin
                        meas_reg <= meas_c;
                        if (seed_path_c)
                        begin
                            // Seed from the measurement, reset Q, R and covariance; pass it straight through.
                            est_reg      <= meas_fx_c;
                            cov_reg      <= COV_SEED;
                            seeded_reg   <= 1'b1;
                            q_reg        <= Q_SEED;
                            r_reg        <= R_SEED;
                            res_filt_reg <= meas_c;
                            res_dev_reg  <= '0;
                            res_seed_reg <= 1'b1;
                            state_reg    <= ST_FIN;
                        end
                        else
                        begin
                            innov_reg      <= innov_c;
                            ppred_reg      <= ppred_c;
                            denom_reg      <= denom_c;
                            denom_zero_reg <= (denom_c == '0);
                            res_seed_reg   <= 1'b0;
                            state_reg      <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    // Hold until the divider retires the last quotient bit.
                    if (div_stat.done && !div_stat.busy)
                    begin
                        gain_reg  <= denom_zero_reg ? '0 : div_quot;
                        state_reg <= ST_MULK;
                    end
                end
                ST_MULK:
                begin
                    prod_reg  <= mul_p_c;
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    est_reg   <= est_new_c;
                    prod_reg  <= mul_p_c;
                    state_reg <= ST_COV;
                end
                ST_COV:
                begin
                    cov_reg      <= cov_new_c;
                    res_filt_reg <= filt_c;
                    res_dev_reg  <= dev_c;
                    state_reg    <= ST_FIN;
                end
                ST_FIN:
                begin
                    // Advance once the output register is free or being emptied.
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_filt_reg  <= res_filt_reg;
                        out_dev_reg   <= res_dev_reg;
                        out_seed_reg  <= res_seed_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-2*MV_W){1'b0}}, out_dev_reg, out_filt_reg};
    assign m_axis_tuser  = out_seed_reg;

endmodule

/* rtl/skf_chk.sv */
`include "scalar_kalman_voltage_filter_unit_macros.svh"

module skf_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [skf_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic                           m_axis_tuser
);
    import skf_pkg::*;

    // One item at a time: ready drops right after an input transaction.
    `SKF_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready stayed high after an input transaction")

    // A seeding result passes the measurement through, so it shows no deviation.
    `SKF_ASSERT_SAME(a_seed_no_dev, m_axis_tvalid && m_axis_tuser, m_axis_tdata[2*MV_W-1:MV_W] == '0, "seeding result with nonzero deviation")

    `SKF_ASSERT_NEXT(a_out_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result withdrawn while stalled")

    `SKF_ASSERT_NEXT(a_out_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

endmodule

bind scalar_kalman_voltage_filter_unit skf_chk u_skf_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
